@@ hdl/nlf_pkg.sv @@
// Shared types and constants for the navigation-light flasher.
// Holds light character codes, slot limits and the register bundle.
// No dependencies.
package nlf_pkg;

  localparam int SLOT_W = 7;
  localparam int CHAR_W = 5;
  localparam int PERIOD_W = 10;
  localparam int GROUP_W = 4;

  localparam logic [SLOT_W-1:0] MAX_SLOTS = 7'd100;
  localparam logic [SLOT_W-1:0] MIN_SLOTS = 7'd4;
  localparam logic [SLOT_W-1:0] DEFAULT_SLOTS = 7'd16;
  localparam logic [SLOT_W-1:0] LONG_SLOTS = 7'd8;
  localparam logic [SLOT_W-1:0] SHORT_FLASH_SLOTS = 7'd4;

  localparam logic [CHAR_W-1:0] CHAR_FIXED = 5'd1;
  localparam logic [CHAR_W-1:0] CHAR_FLASH = 5'd2;
  localparam logic [CHAR_W-1:0] CHAR_LONG = 5'd3;
  localparam logic [CHAR_W-1:0] CHAR_QUICK = 5'd4;
  localparam logic [CHAR_W-1:0] CHAR_VQUICK = 5'd5;
  localparam logic [CHAR_W-1:0] CHAR_ISO = 5'd7;
  localparam logic [CHAR_W-1:0] CHAR_OCCULT = 5'd8;

  localparam logic [1:0] REG_CHARACTER = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_GROUP = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0]   character;
    logic [PERIOD_W-1:0] period;
    logic [GROUP_W-1:0]  group;
  } cfg_t;

  typedef struct packed {
    logic              light;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } slot_res_t;

endpackage

@@ hdl/nav_light_flash_pattern.sv @@
// Top level of the navigation-light flasher: tick input register, slot
// counter, result register. Depends on nlf_pkg, nlf_regs and nlf_decode.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   tick     | tick_valid / tick_stall | restart
//   slot     | slot_valid / slot_stall | light_on, slot_index, cycle_end
//   config   | APB, pready tied high   | paddr[3:0], pwdata, prdata
//
// One tick per cycle sustained while slot_stall is low; a tick that is taken goes into the input
// register, then is decoded into the result register that drives the slot ports.
// The slot counter advances as each tick moves into the result register.
// Synchronous reset clears the counter and both valid flags and loads the configuration defaults.
// A stalled result holds; the input register keeps taking ticks until it
// too is full, and only then is tick_stall raised.
module nav_light_flash_pattern import nlf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic        restart,
  output logic        slot_valid,
  input  logic        slot_stall,
  output logic        light_on,
  output logic [6:0]  slot_index,
  output logic        cycle_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t              cfg;
  slot_res_t         res;
  logic              hold_valid;
  logic              hold_restart;
  logic              advance;
  logic [SLOT_W-1:0] counter;
  logic [SLOT_W-1:0] counter_next;

  nlf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nlf_decode u_decode (
    .cfg     (cfg),
    .counter (counter),
    .restart (hold_restart),
    .res     (res)
  );

  assign advance = hold_valid && (!slot_valid || !slot_stall);
  assign tick_stall = hold_valid && !advance;
  assign counter_next = res.last ? '0 : res.slot + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!tick_stall) begin
      hold_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      hold_restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (advance) begin
      counter <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (advance) begin
      slot_valid <= 1'b1;
    end else if (!slot_stall) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      light_on <= res.light;
      slot_index <= res.slot;
      cycle_end <= res.last;
    end
  end

`ifndef SYNTH
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    advance && !res.last |=> counter == $past(res.slot) + SLOT_W'(1))
    else $error("slot counter did not step past the reported slot");

  a_wrap_at_end: assert property (@(posedge clk) disable iff (rst)
    advance && res.last |=> counter == '0 && cycle_end)
    else $error("slot counter did not wrap at the end of the cycle");

  a_restart_slot0: assert property (@(posedge clk) disable iff (rst)
    advance && hold_restart |=> slot_valid && slot_index == '0)
    else $error("restart did not report slot zero");
`endif

endmodule

@@ hdl/nlf_regs.sv @@
// APB register file for the flasher: character, period and group count.
// Depends on nlf_pkg.
module nlf_regs import nlf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.character <= CHAR_FIXED;
      cfg.period <= '0;
      cfg.group <= GROUP_W'(1);
    end else if (wr_en) begin
      case (reg_index)
        REG_CHARACTER: cfg.character <= pwdata[CHAR_W-1:0];
        REG_PERIOD:    cfg.period <= pwdata[PERIOD_W-1:0];
        REG_GROUP:     cfg.group <= pwdata[GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CHARACTER: prdata = {{(32-CHAR_W){1'b0}}, cfg.character};
      REG_PERIOD:    prdata = {{(32-PERIOD_W){1'b0}}, cfg.period};
      REG_GROUP:     prdata = {{(32-GROUP_W){1'b0}}, cfg.group};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/nlf_decode.sv @@
// Slot decode: cycle length, current slot, lamp state and end of cycle.
// Pure combinational logic; depends on nlf_pkg.
module nlf_decode import nlf_pkg::*; (
  input  cfg_t              cfg,
  input  logic [SLOT_W-1:0] counter,
  input  logic              restart,
  output slot_res_t         res
);

  logic [SLOT_W-1:0] base_len;
  logic [SLOT_W-1:0] span;
  logic [SLOT_W-1:0] cycle_len;
  logic [SLOT_W-1:0] slot_raw;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W:0]   slot_plus4;
  logic              multi_group;

  always_comb begin
    if (cfg.period == '0) begin
      base_len = DEFAULT_SLOTS;
    end else if (cfg.period < PERIOD_W'(MIN_SLOTS)) begin
      base_len = MIN_SLOTS;
    end else if (cfg.period > PERIOD_W'(MAX_SLOTS)) begin
      base_len = MAX_SLOTS;
    end else begin
      base_len = cfg.period[SLOT_W-1:0];
    end
  end

  // group of g two-slot flashes spans 4g-2 slots
  assign span = {1'b0, cfg.group, 2'b00} - SLOT_W'(2);
  assign multi_group = (cfg.group >= GROUP_W'(2));

  always_comb begin
    cycle_len = base_len;
    if (cfg.character == CHAR_FLASH && multi_group && span > base_len) begin
      cycle_len = span;
    end else if (cfg.character == CHAR_LONG && base_len < LONG_SLOTS) begin
      cycle_len = LONG_SLOTS;
    end
  end

  assign slot_raw = restart ? '0 : counter;
  // drop back to slot 0 when a shorter cycle left the counter past its end
  assign slot = (slot_raw >= cycle_len) ? '0 : slot_raw;
  assign slot_plus4 = {1'b0, slot} + (SLOT_W+1)'(4);

  always_comb begin
    case (cfg.character)
      CHAR_FIXED:  res.light = 1'b1;
      CHAR_FLASH:  res.light = multi_group ? (slot < span && !slot[1])
                                           : (slot < SHORT_FLASH_SLOTS);
      CHAR_LONG:   res.light = (slot < LONG_SLOTS);
      CHAR_QUICK:  res.light = (slot[1:0] == 2'b00);
      CHAR_VQUICK: res.light = !slot[0];
      CHAR_ISO:    res.light = (slot < (base_len >> 1));
      CHAR_OCCULT: res.light = (slot_plus4 < {1'b0, base_len});
      default:     res.light = (slot < SHORT_FLASH_SLOTS);
    endcase
  end

  assign res.slot = slot;
  assign res.last = (slot + SLOT_W'(1) == cycle_len);

endmodule

@@ tb/nav_light_flash_pattern_test.sv @@
`timescale 1ns / 100ps
// Testbench for nav_light_flash_pattern: drives ticks and APB register writes,
// predicts every slot result in a scoreboard class and checks it in order.
// Depends on nlf_pkg and the nav_light_flash_pattern RTL.
module nav_light_flash_pattern_test;
  import nlf_pkg::*;

  class lamp_slot_board;
    logic [CHAR_W-1:0]   character;
    logic [PERIOD_W-1:0] period;
    logic [GROUP_W-1:0]  group;
    int unsigned         slot_counter;
    slot_res_t           slots_due[$];
    int                  errors;

    function new();
      character = CHAR_FIXED;
      period = '0;
      group = 4'd1;
      slot_counter = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_CHARACTER: character = value[CHAR_W-1:0];
        REG_PERIOD:    period = value[PERIOD_W-1:0];
        REG_GROUP:     group = value[GROUP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return slots_due.size();
    endfunction

    // Work out the slot this tick reports, then advance the counter.
    function void take_tick(logic restart);
      int unsigned t, len, s, g;
      logic        lit, last;
      slot_res_t   due;
      g = group;
      if (period == 0) t = DEFAULT_SLOTS;
      else if (period < MIN_SLOTS) t = MIN_SLOTS;
      else if (period > MAX_SLOTS) t = MAX_SLOTS;
      else t = period;
      len = t;
      if (character == CHAR_FLASH && g >= 2) begin
        if (4 * g - 2 > t) len = 4 * g - 2;
      end else if (character == CHAR_LONG && t < LONG_SLOTS) begin
        len = LONG_SLOTS;
      end
      s = restart ? 0 : slot_counter;
      // a shortened cycle leaves the counter past the end: report slot 0
      if (s >= len) s = 0;
      last = (s + 1 == len);
      case (character)
        CHAR_FIXED:  lit = 1'b1;
        CHAR_FLASH:  lit = (g <= 1) ? (s < SHORT_FLASH_SLOTS)
                                    : (s < 4 * g - 2 && (s % 4) < 2);
        CHAR_LONG:   lit = (s < LONG_SLOTS);
        CHAR_QUICK:  lit = (s % 4 == 0);
        CHAR_VQUICK: lit = (s % 2 == 0);
        CHAR_ISO:    lit = (s < t / 2);
        CHAR_OCCULT: lit = (s + 4 < t);
        default:     lit = (s < SHORT_FLASH_SLOTS);
      endcase
      due.light = lit;
      due.slot = 7'(s);
      due.last = last;
      slots_due = {slots_due, due};
      slot_counter = last ? 0 : s + 1;
    endfunction

    function void check_slot(logic light, logic [6:0] slot, logic last);
      slot_res_t due;
      if (slots_due.size() == 0) begin
        $error("slot result with none pending: light_on %0b slot_index %0d cycle_end %0b",
               light, slot, last);
        errors++;
        return;
      end
      due = slots_due.pop_front();
      if (light !== due.light) begin
        $error("light_on: expected %0b, got %0b", due.light, light);
        errors++;
      end
      if (slot !== due.slot) begin
        $error("slot_index: expected %0d, got %0d", due.slot, slot);
        errors++;
      end
      if (last !== due.last) begin
        $error("cycle_end: expected %0b, got %0b", due.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  logic        restart = 1'b0;
  logic        slot_valid;
  logic        slot_stall = 1'b0;
  logic        light_on;
  logic [6:0]  slot_index;
  logic        cycle_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lamp_slot_board board = new();
  int sender_pct = 0;
  int stall_pct = 0;
  int ticks_sent = 0;

  logic [CHAR_W-1:0] char_codes[7] = '{CHAR_FIXED, CHAR_FLASH, CHAR_LONG, CHAR_QUICK,
                                       CHAR_VQUICK, CHAR_ISO, CHAR_OCCULT};

  nav_light_flash_pattern uut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_stall(tick_stall), .restart(restart),
    .slot_valid(slot_valid), .slot_stall(slot_stall),
    .light_on(light_on), .slot_index(slot_index), .cycle_end(cycle_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(negedge clk) begin
    slot_stall <= rst ? 1'b0 : roll(stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && slot_valid && !slot_stall) begin
      board.check_slot(light_on, slot_index, cycle_end);
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write the registers only once every pending slot has come back.
  task automatic configure(input logic [CHAR_W-1:0] chr, input logic [PERIOD_W-1:0] per,
                           input logic [GROUP_W-1:0] grp);
    drain();
    apb_write(REG_CHARACTER, 32'(chr));
    apb_write(REG_PERIOD, 32'(per));
    apb_write(REG_GROUP, 32'(grp));
  endtask

  task automatic drive_ticks(input int count, input int restart_pct);
    int taken;
    bit holding;
    taken = 0;
    holding = 0;
    while (taken < count) begin
      @(negedge clk);
      if (!holding) begin
        if (roll(sender_pct)) begin
          tick_valid <= 1'b0;
        end else begin
          tick_valid <= 1'b1;
          restart <= roll(restart_pct);
          holding = 1;
        end
      end
      @(posedge clk);
      if (holding && !tick_stall) begin
        board.take_tick(restart);
        holding = 0;
        taken++;
      end
    end
    ticks_sent += count;
    @(negedge clk);
    tick_valid <= 1'b0;
    restart <= 1'b0;
  endtask

  initial begin
    int phase;
    logic [CHAR_W-1:0]   chr;
    logic [PERIOD_W-1:0] per;
    logic [GROUP_W-1:0]  grp;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, then a restart
    drive_ticks(2, 0);
    drive_ticks(1, 100);
    // short periods clamp up, group zero acts as a single flash
    configure(CHAR_FLASH, 10'd1, 4'd0);
    drive_ticks(2, 0);
    // largest group and period extremes
    configure(CHAR_FLASH, 10'd1023, 4'd15);
    drive_ticks(2, 0);
    configure(CHAR_LONG, 10'd4, 4'd9);
    drive_ticks(2, 0);
    configure(CHAR_QUICK, 10'd5, 4'd1);
    drive_ticks(2, 0);
    configure(CHAR_VQUICK, 10'd3, 4'd1);
    drive_ticks(2, 0);
    configure(CHAR_ISO, 10'd7, 4'd1);
    drive_ticks(2, 0);
    configure(CHAR_OCCULT, 10'd4, 4'd1);
    drive_ticks(2, 0);
    configure(5'd31, 10'd100, 4'd1);
    drive_ticks(2, 0);
    configure(5'd0, 10'd101, 4'd2);
    drive_ticks(2, 0);
    // shorten the cycle while the counter sits past its new end
    configure(CHAR_FIXED, 10'd100, 4'd1);
    drive_ticks(6, 0);
    configure(CHAR_FIXED, 10'd2, 4'd1);
    drive_ticks(1, 0);

    phase = 0;
    while (ticks_sent < 1630) begin
      chr = roll(25) ? 5'($urandom_range(0, 31)) : char_codes[$urandom_range(0, 6)];
      case ($urandom_range(0, 5))
        0:       per = 10'($urandom_range(0, 3));
        1:       per = 10'($urandom_range(97, 1023));
        default: per = 10'($urandom_range(4, 24));
      endcase
      grp = roll(20) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 9));
      configure(chr, per, grp);
      case (phase % 4)
        0: begin sender_pct = 0;  stall_pct = 0;  end
        1: begin sender_pct = 50; stall_pct = 0;  end
        2: begin sender_pct = 0;  stall_pct = 50; end
        default: begin sender_pct = 7; stall_pct = 7; end
      endcase
      drive_ticks($urandom_range(8, 72), 6);
      phase++;
    end

    sender_pct = 0;
    drain();
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("[nav_light_flash_pattern] OK");
    end else begin
      $display("[nav_light_flash_pattern] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[nav_light_flash_pattern] ERROR");
    $finish;
  end

endmodule
